FILE: src/nut_pkg.sv
// Package: shared widths, character and header codes, request types, register indexes and limits for the extractor.
`timescale 1ns / 1ps
package nut_pkg;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 20;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_VT    = 8'd11;
   localparam logic [7:0] CH_FF    = 8'd12;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_DOLLAR = 8'd36;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_G     = 8'd71;
   localparam logic [7:0] CH_L     = 8'd76;
   localparam logic [7:0] CH_N     = 8'd78;
   localparam logic [7:0] CH_P     = 8'd80;
   localparam logic [7:0] CH_Q     = 8'd81;
   localparam logic [23:0] HDR_ZDA = 24'h5A4441;
   localparam logic [23:0] HDR_RMC = 24'h524D43;
   localparam logic [23:0] HDR_GGA = 24'h474741;

   localparam logic [0:0] REQ_BYTE = 1'b0;
   localparam logic [0:0] REQ_TICK = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRESH_WINDOW = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZDA_HOLD     = 8'd1;

   localparam logic [19:0] MS_TIME_MAX = 20'hFFFFF;
   localparam logic [15:0] MS_ZDA_MAX  = 16'hFFFF;
   localparam logic [10:0] MIN_PER_DAY = 11'd1440;
endpackage

FILE: src/nut_req_if.sv
// Interface: request channel carrying one byte or tick beat.
`timescale 1ns / 1ps
interface nut_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] rx_byte;
   modport source (output valid, req_type, rx_byte, input ready);
   modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

FILE: src/nut_rsp_if.sv
// Interface: result channel carrying one time report beat.
`timescale 1ns / 1ps
interface nut_rsp_if;
   logic              valid;
   logic              ready;
   logic              time_fresh;
   logic [4:0]        utc_hour;
   logic [5:0]        utc_minute;
   logic [4:0]        local_hour;
   logic [5:0]        local_minute;
   logic signed [14:0] zone_offset_min;
   logic              time_updated;
   logic              from_zda;
   modport source (output valid, time_fresh, utc_hour, utc_minute, local_hour, local_minute,
                   zone_offset_min, time_updated, from_zda, input ready);
   modport sink   (input valid, time_fresh, utc_hour, utc_minute, local_hour, local_minute,
                   zone_offset_min, time_updated, from_zda, output ready);
endinterface

FILE: src/nut_csr_if.sv
// Interface: register write channel.
`timescale 1ns / 1ps
interface nut_csr_if;
   logic                           valid;
   logic                           ready;
   logic [nut_pkg::CSR_INDEX_W-1:0] index;
   logic [nut_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/nmea_utc_time_extractor.sv
// Top level: NMEA ZDA/RMC/GGA UTC time parser with local time report.
// Throughput: one beat per cycle unless the output stalls. The byte parser updates state
//   in the accept cycle; the s1 register and three registered stages (offset add,
//   mod-1440 reduction, hour/minute split) carry the result to the output register.
// The request side stalls only while a finished result waits at the output.
// Synchronous active-high reset clears parser, saved time, counters and pipeline valids;
//   registers return to 300000 ms fresh window and 4000 ms ZDA hold.
`timescale 1ns / 1ps
module nmea_utc_time_extractor #(
   parameter int unsigned LINE_MAX = 255
) (
   input logic clock,
   input logic reset,
   nut_req_if.sink   req_chan,
   nut_rsp_if.source rsp_chan,
   nut_csr_if.sink   csr_chan
);
   import nut_pkg::*;

   localparam int unsigned LC_W = $clog2(LINE_MAX + 1);

   typedef enum logic [3:0] {
      PH_LEAD, PH_HEADER, PH_TSKIP, PH_TCHARS, PH_AFTER, PH_ZONEH, PH_ZONEM, PH_IDLE
   } phase_type;

   typedef struct packed {
      logic [9:0] acc;
      logic       neg;
      logic [1:0] sub;
   } zone_type;

   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // sub: 0 skipping blanks, 1 in digits, 2 finished
   function automatic zone_type zone_step(input zone_type z, input logic [7:0] c,
                                          input logic [9:0] limit);
      zone_type r;
      logic     go;
      logic [13:0] prod;
      r  = z;
      go = 1'b0;
      prod = '0;
      if (z.sub == 2'd0) begin
         if (is_blank(c)) begin
            go = 1'b0;
         end else if (c == CH_MINUS) begin
            r.neg = 1'b1;
            r.sub = 2'd1;
         end else if (c == CH_PLUS) begin
            r.sub = 2'd1;
         end else begin
            r.sub = 2'd1;
            go = 1'b1;
         end
      end else if (z.sub == 2'd1) begin
         go = 1'b1;
      end
      if (go) begin
         if (is_digit(c)) begin
            prod = ({4'd0, z.acc} << 3) + ({4'd0, z.acc} << 1) + {6'd0, c - CH_ZERO};
            r.acc = prod[9:0];
            if (prod[9:0] > limit) r.sub = 2'd2;
         end else begin
            r.sub = 2'd2;
         end
      end
      zone_step = r;
   endfunction

   function automatic logic [6:0] bcd2(input logic [3:0] t, input logic [3:0] o);
      bcd2 = ({3'd0, t} << 3) + ({3'd0, t} << 1) + {3'd0, o};
   endfunction

   // ---------------- registers ----------------
   logic [19:0] fresh_win_ff;
   logic [15:0] zda_hold_ff;

   logic [LC_W-1:0] line_count_ff, line_count_in;
   phase_type       phase_ff, phase_in;
   logic [39:0]     hdr_ff, hdr_in;
   logic [2:0]      hdr_len_ff, hdr_len_in;
   logic            hdr_hit_ff, hdr_hit_in;
   logic            line_zda_ff, line_zda_in;
   logic            line_good_ff, line_good_in;
   logic [2:0]      comma_ff, comma_in;
   logic [23:0]     digits_ff, digits_in;
   logic [2:0]      time_len_ff, time_len_in;
   zone_type        zh_ff, zh_in, zm_ff, zm_in;

   logic [4:0]         hour_ff, hour_in;
   logic [5:0]         minute_ff, minute_in;
   logic               saved_valid_ff, saved_valid_in;
   logic signed [14:0] offset_ff, offset_in;
   logic [19:0]        ms_time_ff, ms_time_in;
   logic [15:0]        ms_zda_ff, ms_zda_in;
   logic               zda_seen_ff, zda_seen_in;
   logic               upd_in, byzda_in;

   logic               s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic               s1_sv_ff, s1_upd_ff, s1_zda_ff;
   logic [19:0]        s1_mst_ff;
   logic [4:0]         s1_h_ff, s2_h_ff, s3_h_ff;
   logic [5:0]         s1_m_ff, s2_m_ff, s3_m_ff;
   logic signed [14:0] s1_off_ff, s2_off_ff, s3_off_ff;
   logic               s2_fresh_ff, s3_fresh_ff, s2_upd_ff, s3_upd_ff, s2_zda_ff, s3_zda_ff;
   logic [14:0]        s2_total_ff;
   logic [10:0]        s3_r_ff;

   logic advance, req_take;
   assign advance  = !(out_v_ff && !rsp_chan.ready);
   assign req_take = req_chan.valid && advance;
   assign req_chan.ready = advance;
   assign csr_chan.ready = 1'b1;

   // ---------------- parser and saved state ----------------
   always_comb begin
      logic [7:0]  c;
      logic [2:0]  cc_inc;
      logic [23:0] low3;
      logic [3:0]  d5, d4, d3, d2, d1, d0;
      logic        take_t;
      logic        good;
      logic        supp;
      logic [9:0]  hv, mv;
      logic signed [14:0] hs, ms;

      c = req_chan.rx_byte;
      cc_inc = (comma_ff < 3'd7) ? comma_ff + 3'd1 : comma_ff;
      line_count_in = line_count_ff;
      phase_in = phase_ff;
      hdr_in = hdr_ff;
      hdr_len_in = hdr_len_ff;
      hdr_hit_in = hdr_hit_ff;
      line_zda_in = line_zda_ff;
      line_good_in = line_good_ff;
      comma_in = comma_ff;
      digits_in = digits_ff;
      time_len_in = time_len_ff;
      zh_in = zh_ff;
      zm_in = zm_ff;
      hour_in = hour_ff;
      minute_in = minute_ff;
      saved_valid_in = saved_valid_ff;
      offset_in = offset_ff;
      ms_time_in = ms_time_ff;
      ms_zda_in = ms_zda_ff;
      zda_seen_in = zda_seen_ff;
      upd_in = 1'b0;
      byzda_in = 1'b0;
      low3 = '0;
      take_t = 1'b0;
      good = 1'b0;
      supp = 1'b0;
      hv = '0;
      mv = '0;
      hs = '0;
      ms = '0;
      {d5, d4, d3, d2, d1, d0} = digits_ff;

      if (req_chan.req_type == REQ_TICK) begin
         if (ms_time_ff < MS_TIME_MAX) ms_time_in = ms_time_ff + 20'd1;
         if (ms_zda_ff < MS_ZDA_MAX) ms_zda_in = ms_zda_ff + 16'd1;
      end else if (c == CH_CR || c == CH_LF) begin
         supp = !line_zda_ff && zda_seen_ff && (ms_zda_ff < zda_hold_ff);
         if (line_good_ff && !supp) begin
            hour_in = 5'(bcd2(d5, d4));
            minute_in = 6'(bcd2(d3, d2));
            saved_valid_in = 1'b1;
            ms_time_in = '0;
            upd_in = 1'b1;
            if (line_zda_ff) begin
               byzda_in = 1'b1;
               if (comma_ff >= 3'd6) begin
                  hv = zh_ff.acc;
                  mv = zm_ff.acc;
                  hs = zh_ff.neg ? -$signed({5'd0, hv}) : $signed({5'd0, hv});
                  ms = zm_ff.neg ? -$signed({5'd0, mv}) : $signed({5'd0, mv});
                  if (mv > 10'd59) ms = '0;
                  offset_in = (hs <<< 6) - (hs <<< 2) + ms;
               end
               ms_zda_in = '0;
               zda_seen_in = 1'b1;
            end
         end
         // clear line
         line_count_in = '0;
         phase_in = PH_LEAD;
         hdr_in = '0;
         hdr_len_in = '0;
         hdr_hit_in = 1'b0;
         line_zda_in = 1'b0;
         line_good_in = 1'b0;
         comma_in = '0;
         digits_in = '0;
         time_len_in = '0;
         zh_in = '0;
         zm_in = '0;
      end else if (line_count_ff < LC_W'(LINE_MAX)) begin
         line_count_in = line_count_ff + LC_W'(1);
         if (c == CH_NUL) begin
            phase_in = PH_IDLE;
         end else begin
            case (phase_ff)
               PH_LEAD: begin
                  if (!is_blank(c)) phase_in = (c == CH_DOLLAR) ? PH_HEADER : PH_IDLE;
               end
               PH_HEADER: begin
                  if (c == CH_COMMA) begin
                     comma_in = cc_inc;
                     low3 = hdr_ff[23:0];
                     line_zda_in = (hdr_len_ff == 3'd5) && (low3 == HDR_ZDA) &&
                        (hdr_ff[39:32] == CH_G) &&
                        (hdr_ff[31:24] == CH_P || hdr_ff[31:24] == CH_N ||
                         hdr_ff[31:24] == CH_L || hdr_ff[31:24] == CH_Q);
                     phase_in = (line_zda_in || hdr_hit_ff) ? PH_TSKIP : PH_IDLE;
                  end else begin
                     hdr_in = {hdr_ff[31:0], c};
                     if (hdr_len_ff < 3'd6) hdr_len_in = hdr_len_ff + 3'd1;
                     low3 = hdr_in[23:0];
                     if (hdr_len_in >= 3'd3 && (low3 == HDR_RMC || low3 == HDR_GGA))
                        hdr_hit_in = 1'b1;
                  end
               end
               PH_TSKIP: begin
                  if (c == CH_COMMA) begin
                     phase_in = PH_IDLE;
                  end else if (!is_blank(c)) begin
                     phase_in = PH_TCHARS;
                     take_t = 1'b1;
                  end
               end
               PH_TCHARS: begin
                  take_t = 1'b1;
               end
               PH_AFTER: begin
                  if (c == CH_COMMA) begin
                     comma_in = cc_inc;
                     if (cc_inc == 3'd5) begin
                        phase_in = PH_ZONEH;
                        zh_in.sub = 2'd0;
                     end
                  end
               end
               PH_ZONEH: begin
                  if (c == CH_COMMA) begin
                     comma_in = cc_inc;
                     phase_in = PH_ZONEM;
                     zm_in.sub = 2'd0;
                  end else begin
                     zh_in = zone_step(zh_ff, c, 10'd13);
                  end
               end
               PH_ZONEM: begin
                  if (c == CH_COMMA) begin
                     comma_in = cc_inc;
                     zm_in.sub = 2'd2;
                  end else begin
                     zm_in = zone_step(zm_ff, c, 10'd59);
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
            if (take_t) begin
               if (c == CH_COMMA) begin
                  comma_in = cc_inc;
                  good = line_good_ff;
                  if (time_len_ff >= 3'd6) begin
                     good = (d5 < 4'd2 || (d5 == 4'd2 && d4 <= 4'd3)) &&
                            (d3 <= 4'd5) && (d1 <= 4'd5);
                  end
                  line_good_in = good;
                  phase_in = (good && line_zda_ff) ? PH_AFTER : PH_IDLE;
               end else if (time_len_ff < 3'd6) begin
                  if (!is_digit(c)) begin
                     phase_in = PH_IDLE;
                  end else begin
                     digits_in = {digits_ff[19:0], c[3:0]};
                     time_len_in = time_len_ff + 3'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_win_ff <= 20'd300000;
         zda_hold_ff <= 16'd4000;
         line_count_ff <= '0;
         phase_ff <= PH_LEAD;
         hdr_ff <= '0;
         hdr_len_ff <= '0;
         hdr_hit_ff <= 1'b0;
         line_zda_ff <= 1'b0;
         line_good_ff <= 1'b0;
         comma_ff <= '0;
         digits_ff <= '0;
         time_len_ff <= '0;
         zh_ff <= '0;
         zm_ff <= '0;
         hour_ff <= '0;
         minute_ff <= '0;
         saved_valid_ff <= 1'b0;
         offset_ff <= '0;
         ms_time_ff <= '0;
         ms_zda_ff <= '0;
         zda_seen_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            if (csr_chan.index == CSR_FRESH_WINDOW) fresh_win_ff <= csr_chan.data;
            else if (csr_chan.index == CSR_ZDA_HOLD) zda_hold_ff <= csr_chan.data[15:0];
         end
         if (req_take) begin
            line_count_ff <= line_count_in;
            phase_ff <= phase_in;
            hdr_ff <= hdr_in;
            hdr_len_ff <= hdr_len_in;
            hdr_hit_ff <= hdr_hit_in;
            line_zda_ff <= line_zda_in;
            line_good_ff <= line_good_in;
            comma_ff <= comma_in;
            digits_ff <= digits_in;
            time_len_ff <= time_len_in;
            zh_ff <= zh_in;
            zm_ff <= zm_in;
            hour_ff <= hour_in;
            minute_ff <= minute_in;
            saved_valid_ff <= saved_valid_in;
            offset_ff <= offset_in;
            ms_time_ff <= ms_time_in;
            ms_zda_ff <= ms_zda_in;
            zda_seen_ff <= zda_seen_in;
         end
         if (advance) begin
            s1_v_ff <= req_take;
            s2_v_ff <= s1_v_ff;
            s3_v_ff <= s2_v_ff;
            out_v_ff <= s3_v_ff;
         end
      end
   end

   // ---------------- local time pipeline ----------------
   logic [15:0] total_sum;
   logic [20:0] q_prod;
   logic [3:0]  q_est;
   logic [14:0] r_raw;
   logic [10:0] r_fix;
   logic [21:0] h_prod;
   logic [4:0]  loc_h;
   logic [10:0] loc_m;

   // offset + 8640 keeps the sum positive
   assign total_sum = 16'($signed({6'd0, s1_h_ff, 6'd0}) - $signed({8'd0, s1_h_ff, 2'd0}) +
                         $signed({10'd0, s1_m_ff}) + $signed({s1_off_ff[14], s1_off_ff}) +
                         16'sd8640);
   // quotient estimate may come out one low; one conditional subtract fixes it
   assign q_prod = {6'd0, s2_total_ff} * 21'd45;
   assign q_est  = q_prod[19:16];
   assign r_raw  = s2_total_ff - 15'({11'd0, q_est} * 15'd1440);
   assign r_fix  = (r_raw >= {4'd0, MIN_PER_DAY}) ? 11'(r_raw - {4'd0, MIN_PER_DAY})
                                                  : r_raw[10:0];
   assign h_prod = {11'd0, s3_r_ff} * 22'd1093;
   assign loc_h  = h_prod[20:16];
   assign loc_m  = s3_r_ff - (({6'd0, loc_h} << 6) - ({6'd0, loc_h} << 2));

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sv_ff  <= saved_valid_in;
         s1_mst_ff <= ms_time_in;
         s1_h_ff   <= hour_in;
         s1_m_ff   <= minute_in;
         s1_off_ff <= offset_in;
         s1_upd_ff <= upd_in;
         s1_zda_ff <= byzda_in;

         s2_fresh_ff <= s1_sv_ff && (s1_mst_ff < fresh_win_ff);
         s2_total_ff <= total_sum[14:0];
         s2_h_ff <= s1_h_ff;
         s2_m_ff <= s1_m_ff;
         s2_off_ff <= s1_off_ff;
         s2_upd_ff <= s1_upd_ff;
         s2_zda_ff <= s1_zda_ff;

         s3_fresh_ff <= s2_fresh_ff;
         s3_h_ff <= s2_h_ff;
         s3_m_ff <= s2_m_ff;
         s3_off_ff <= s2_off_ff;
         s3_upd_ff <= s2_upd_ff;
         s3_zda_ff <= s2_zda_ff;
         s3_r_ff <= r_fix;

         rsp_chan.time_fresh      <= s3_fresh_ff;
         rsp_chan.utc_hour        <= s3_fresh_ff ? s3_h_ff : 5'd0;
         rsp_chan.utc_minute      <= s3_fresh_ff ? s3_m_ff : 6'd0;
         rsp_chan.local_hour      <= s3_fresh_ff ? loc_h : 5'd0;
         rsp_chan.local_minute    <= s3_fresh_ff ? loc_m[5:0] : 6'd0;
         rsp_chan.zone_offset_min <= s3_off_ff;
         rsp_chan.time_updated    <= s3_upd_ff;
         rsp_chan.from_zda        <= s3_zda_ff;
      end
   end

   assign rsp_chan.valid = out_v_ff;

   a_zda_implies_update: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (!rsp_chan.from_zda || rsp_chan.time_updated))
      else $error("from_zda without time_updated");
   a_stale_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.time_fresh) |->
      (rsp_chan.utc_hour == 5'd0 && rsp_chan.local_hour == 5'd0 &&
       rsp_chan.local_minute == 6'd0))
      else $error("stale time not zeroed");
   a_local_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.local_hour <= 5'd23 && rsp_chan.local_minute <= 6'd59))
      else $error("local time out of range");
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken during output stall");
endmodule
